// File: design/gfau_pkg.sv
package gfau_pkg;

	localparam logic [8:0] GF_POLY    = 9'h11B;
	localparam logic [7:0] GF_INV_EXP = 8'd254;
	localparam logic [7:0] GF_ONE     = 8'h01;
	localparam int unsigned EXP_BITS  = 8;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_MUL = 3'd1,
		ACT_POW = 3'd2,
		ACT_INV = 3'd3,
		ACT_DIV = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MSEL_ACC_BASE,
		MSEL_BASE_BASE,
		MSEL_A_ACC,
		MSEL_A_B
	} mul_sel_t;

	typedef enum logic [1:0] {
		RES_XOR,
		RES_MUL,
		RES_ACC,
		RES_ZERO
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     step_mul;
		logic     step_sqr;
		logic     step_fin;
		logic     write_out;
		mul_sel_t mul_sel;
		res_sel_t res_sel;
	} gfau_cmd_t;

	// Multiply in GF(2^8): Horner form, one shift-and-reduce per bit of y.
	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] p;
		p = '0;
		for (int k = 7; k >= 0; k--) begin
			p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY[7:0] : 8'h00);
			if (y[k]) begin
				p = p ^ x;
			end
		end
		return p;
	endfunction

endpackage

// File: design/gfau_dp.sv
module gfau_dp (
	input  logic               clk,
	input  logic [2:0]         action,
	input  logic [7:0]         operand_a,
	input  logic [7:0]         operand_b,
	input  gfau_pkg::gfau_cmd_t cmd,
	output logic [7:0]         result
);
	import gfau_pkg::*;

	logic [7:0] a_q, b_q, acc_q, base_q, exp_q, result_q;
	logic [7:0] mul_x, mul_y, prod;

	always_comb begin
		unique case (cmd.mul_sel)
			MSEL_ACC_BASE:  begin mul_x = acc_q;  mul_y = base_q; end
			MSEL_BASE_BASE: begin mul_x = base_q; mul_y = base_q; end
			MSEL_A_ACC:     begin mul_x = a_q;    mul_y = acc_q;  end
			default:        begin mul_x = a_q;    mul_y = b_q;    end
		endcase
	end

	// The single shared field multiplier.
	assign prod = gf_mul(mul_x, mul_y);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= operand_a;
			b_q    <= operand_b;
			acc_q  <= GF_ONE;
			base_q <= (action == ACT_DIV) ? operand_b : operand_a;
			exp_q  <= (action == ACT_POW) ? operand_b : GF_INV_EXP;
		end
		if (cmd.step_mul && exp_q[0]) begin
			acc_q <= prod;
		end
		if (cmd.step_sqr) begin
			base_q <= prod;
			exp_q  <= {1'b0, exp_q[7:1]};
		end
		if (cmd.step_fin) begin
			acc_q <= prod;
		end
		if (cmd.write_out) begin
			unique case (cmd.res_sel)
				RES_XOR: result_q <= a_q ^ b_q;
				RES_MUL: result_q <= prod;
				RES_ACC: result_q <= acc_q;
				default: result_q <= '0;
			endcase
		end
	end

	assign result = result_q;

endmodule

// File: design/gfau_ctrl.sv
module gfau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	output logic               out_valid,
	input  logic               out_ready,
	output gfau_pkg::gfau_cmd_t cmd
);
	import gfau_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQR,
		ST_FIN,
		ST_WB
	} state_t;

	localparam logic [2:0] LAST_BIT = 3'(EXP_BITS - 1);

	state_t     state_q;
	logic [2:0] bit_q;
	logic       div_q;
	res_sel_t   res_q;
	logic       out_valid_q;
	res_sel_t   res_dec;

	always_comb begin
		unique case (action) inside
			ACT_ADD:                   res_dec = RES_XOR;
			ACT_MUL:                   res_dec = RES_MUL;
			ACT_POW, ACT_INV, ACT_DIV: res_dec = RES_ACC;
			default:                   res_dec = RES_ZERO;
		endcase
	end

	always_comb begin
		cmd = '{load: 1'b0, step_mul: 1'b0, step_sqr: 1'b0, step_fin: 1'b0,
			write_out: 1'b0, mul_sel: MSEL_A_B, res_sel: res_q};
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_MUL: begin
				cmd.step_mul = 1'b1;
				cmd.mul_sel  = MSEL_ACC_BASE;
			end
			ST_SQR: begin
				cmd.step_sqr = 1'b1;
				cmd.mul_sel  = MSEL_BASE_BASE;
			end
			ST_FIN: begin
				cmd.step_fin = 1'b1;
				cmd.mul_sel  = MSEL_A_ACC;
			end
			ST_WB: begin
				// The result register is free once the waiting item is taken.
				cmd.write_out = !out_valid_q || out_ready;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= '0;
			div_q       <= 1'b0;
			res_q       <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_q <= res_dec;
						div_q <= (action == ACT_DIV);
						bit_q <= '0;
						state_q <= (res_dec == RES_ACC) ? ST_MUL : ST_WB;
					end
				end
				ST_MUL: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == LAST_BIT) begin
						state_q <= div_q ? ST_FIN : ST_WB;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (cmd.write_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: design/gf256_arith_unit.sv
// Byte arithmetic over GF(2^8) modulo x^8+x^4+x^3+x+1 (0x11B), one item at a time.
// Add, multiply and the unused codes go from the accepting cycle straight to one result
// write. Their result and out_valid are registered at that write, which waits while an
// earlier result is still not taken. For power, inverse and divide the time is set by
// the one shared field multiplier, which walks the eight exponent bits with a multiply
// step and a squaring step each. Divide then adds a final multiply by the dividend.
// Inverse is a^254, so the inverse of zero and any division by zero give zero, and
// a^0 gives 1 for every a. The result register lets a new item be accepted while
// the previous result still waits to be taken. The next result write then waits
// until that result has left.
module gf256_arith_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	input  logic [7:0] operand_a,
	input  logic [7:0] operand_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result
);
	import gfau_pkg::*;

	gfau_cmd_t cmd;

	gfau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	gfau_dp u_dp (
		.clk       (clk),
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.cmd       (cmd),
		.result    (result)
	);

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && in_ready))
		else $error("operands loaded without an accepted item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("unit ready again straight after accepting an item");

	a_valid_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.write_out))
		else $error("result shown without a result write");

	a_one_step_kind: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step_mul, cmd.step_sqr, cmd.step_fin, cmd.write_out}))
		else $error("datapath given more than one command at once");

endmodule
